// ----- hdl/ppd_pkg.sv -----
// Package with the shared types and constants of the PES packet deframer.
package ppd_pkg;

    // Byte status codes reported with every echoed byte.
    typedef enum logic [1:0] {
        ST_DROP   = 2'd0,
        ST_START  = 2'd1,
        ST_LENGTH = 2'd2,
        ST_BODY   = 2'd3
    } t_status;

    // Field widths of the byte and result channels.
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 17;
    localparam int unsigned PTS_W  = 33;

    // Start code prefix, default stream id and header layout.
    localparam logic [BYTE_W-1:0] START_BYTE_0    = 8'h00;
    localparam logic [BYTE_W-1:0] START_BYTE_1    = 8'h00;
    localparam logic [BYTE_W-1:0] START_BYTE_2    = 8'h01;
    localparam logic [BYTE_W-1:0] STREAM_ID_RESET = 8'hBD;
    localparam logic [POS_W-1:0]  HEADER_BYTES    = 17'd6;

    // Offsets inside the packet.
    localparam logic [POS_W-1:0] OFS_START_LAST = 17'd3;
    localparam logic [POS_W-1:0] OFS_LEN_HIGH   = 17'd4;
    localparam logic [POS_W-1:0] OFS_LEN_LOW    = 17'd5;
    localparam logic [POS_W-1:0] OFS_FLAGS      = 17'd7;
    localparam logic [POS_W-1:0] OFS_PTS_0      = 17'd9;
    localparam logic [POS_W-1:0] OFS_PTS_1      = 17'd10;
    localparam logic [POS_W-1:0] OFS_PTS_2      = 17'd11;
    localparam logic [POS_W-1:0] OFS_PTS_3      = 17'd12;
    localparam logic [POS_W-1:0] OFS_PTS_4      = 17'd13;

    // Bit of the flags byte that announces a PTS.
    localparam int unsigned PTS_PRESENT_BIT = 7;

    // One result beat.
    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        t_status           byte_status;
        logic [POS_W-1:0]  byte_position;
        logic              packet_end;
        logic              pts_valid;
        logic [PTS_W-1:0]  pts;
    } t_result;

endpackage

// ----- hdl/ppd_if.sv -----
// Valid/ready channel interfaces for the byte input and the result output.
interface ppd_byte_if;
    import ppd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ppd_result_if;
    import ppd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] echo_byte;
    logic [1:0]        byte_status;
    logic [POS_W-1:0]  byte_position;
    logic              packet_end;
    logic              pts_valid;
    logic [PTS_W-1:0]  pts;

    modport source (
        output valid, output echo_byte, output byte_status, output byte_position,
        output packet_end, output pts_valid, output pts, input ready
    );
    modport sink (
        input valid, input echo_byte, input byte_status, input byte_position,
        input packet_end, input pts_valid, input pts, output ready
    );
endinterface

// ----- hdl/pes_packet_deframer_pts_core.sv -----
// PES packet deframer: start code hunt, length tracking and PTS extraction.
//
// Usage: bytes of a demultiplexed stream enter on i_byte, one beat per byte.
// Every input beat gives exactly one result beat on o_result, carrying the
// echoed byte, its status (dropped, start code, length, body), its offset in
// the packet, an end-of-packet mark and, on the last byte, the 33-bit PTS
// when the flags byte announced one and the packet reached offset 13.
// The matched stream id is set through i_cfg_we / i_cfg_stream_id; the user
// must write it only while the block is idle, which the block itself does not
// enforce. It resets to 0xBD (private stream 1).
// Throughput: one byte per cycle while i_byte.ready is high; the per-byte
// work is one counter update and compare ahead of the result register.
// A two-entry output buffer (result register plus skid register) lets an
// input beat be taken while an earlier result still waits; i_byte.ready
// drops only while both entries are full.
// Reset (synchronous, active low) empties the buffer, restarts the hunt for
// a start code and restores the default stream id.
module pes_packet_deframer_pts_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ppd_pkg::BYTE_W-1:0]  i_cfg_stream_id,
    ppd_byte_if.sink                    i_byte,
    ppd_result_if.source                o_result
);
    import ppd_pkg::*;

    // Configuration and parser state.
    logic [BYTE_W-1:0] r_stream_id;
    logic [POS_W-1:0]  r_byte_index, n_byte_index;
    logic [POS_W-1:0]  r_packet_total, n_packet_total;
    logic [BYTE_W-1:0] r_length_high, n_length_high;
    logic              r_pts_flag, n_pts_flag;
    logic [PTS_W-1:0]  r_pts_accum, n_pts_accum;

    // Output buffer.
    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic              in_take;
    logic              out_pop;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] want;
    logic [POS_W:0]    pos_next;

    assign in_take = i_byte.valid && i_byte.ready;
    assign out_pop = r_out_valid && o_result.ready;
    assign b       = i_byte.data_byte;
    assign pos_next = {1'b0, r_byte_index} + {{POS_W{1'b0}}, 1'b1};

    // Stream id register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_id <= STREAM_ID_RESET;
        end else if (i_cfg_we) begin
            r_stream_id <= i_cfg_stream_id;
        end
    end

    // Expected start code byte at the current offset.
    always_comb begin
        unique case (r_byte_index[1:0])
            2'd0:    want = START_BYTE_0;
            2'd1:    want = START_BYTE_1;
            2'd2:    want = START_BYTE_2;
            default: want = r_stream_id;
        endcase
    end

    // Per-byte parse: next state and the result beat.
    always_comb begin
        n_byte_index   = r_byte_index;
        n_packet_total = r_packet_total;
        n_length_high  = r_length_high;
        n_pts_flag     = r_pts_flag;
        n_pts_accum    = r_pts_accum;

        n_result               = '0;
        n_result.echo_byte     = b;
        n_result.byte_position = r_byte_index;

        if (r_byte_index <= OFS_START_LAST) begin
            // Start code hunt; a mismatch drops the byte without recheck.
            if (b != want) begin
                n_byte_index           = '0;
                n_result.byte_status   = ST_DROP;
                n_result.byte_position = '0;
            end else begin
                n_byte_index         = pos_next[POS_W-1:0];
                n_result.byte_status = ST_START;
            end
        end else if (r_byte_index == OFS_LEN_HIGH) begin
            n_result.byte_status = ST_LENGTH;
            n_length_high        = b;
            n_byte_index         = OFS_LEN_LOW;
        end else if (r_byte_index == OFS_LEN_LOW) begin
            n_result.byte_status = ST_LENGTH;
            n_packet_total       = {1'b0, r_length_high, b} + HEADER_BYTES;
            n_pts_flag           = 1'b0;
            n_pts_accum          = '0;
            if (n_packet_total == HEADER_BYTES) begin
                n_result.packet_end = 1'b1;
                n_byte_index        = '0;
            end else begin
                n_byte_index = HEADER_BYTES;
            end
        end else begin
            n_result.byte_status = ST_BODY;
            // Collect the flag and the PTS fields, skipping marker bits.
            case (r_byte_index)
                OFS_FLAGS: n_pts_flag = b[PTS_PRESENT_BIT];
                OFS_PTS_0: n_pts_accum[32:30] = r_pts_accum[32:30] | b[3:1];
                OFS_PTS_1: n_pts_accum[29:22] = r_pts_accum[29:22] | b;
                OFS_PTS_2: n_pts_accum[21:15] = r_pts_accum[21:15] | b[7:1];
                OFS_PTS_3: n_pts_accum[14:7]  = r_pts_accum[14:7]  | b;
                OFS_PTS_4: n_pts_accum[6:0]   = r_pts_accum[6:0]   | b[7:1];
                default:   ;
            endcase
            if (pos_next >= {1'b0, r_packet_total}) begin
                n_result.packet_end = 1'b1;
                n_byte_index        = '0;
                if (n_pts_flag && (r_packet_total > OFS_PTS_4)) begin
                    n_result.pts_valid = 1'b1;
                    n_result.pts       = n_pts_accum;
                end
            end else begin
                n_byte_index = pos_next[POS_W-1:0];
            end
        end
    end

    // Parser state advances on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index   <= '0;
            r_packet_total <= '0;
            r_length_high  <= '0;
            r_pts_flag     <= 1'b0;
            r_pts_accum    <= '0;
        end else if (in_take) begin
            r_byte_index   <= n_byte_index;
            r_packet_total <= n_packet_total;
            r_length_high  <= n_length_high;
            r_pts_flag     <= n_pts_flag;
            r_pts_accum    <= n_pts_accum;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_take) begin
            if (!r_out_valid || out_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload of the output buffer.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (in_take) begin
            if (!r_out_valid || out_pop) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end
    end

    // Channel ports.
    assign i_byte.ready           = !r_skid_valid;
    assign o_result.valid         = r_out_valid;
    assign o_result.echo_byte     = r_out.echo_byte;
    assign o_result.byte_status   = r_out.byte_status;
    assign o_result.byte_position = r_out.byte_position;
    assign o_result.packet_end    = r_out.packet_end;
    assign o_result.pts_valid     = r_out.pts_valid;
    assign o_result.pts           = r_out.pts;

`ifndef SYNTH
    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without a result in the output register");

    // A timestamp is only reported on the byte that closes a packet.
    a_pts_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.pts_valid) |-> r_out.packet_end)
        else $error("pts_valid outside packet end");

    // Packets end only on a length or body byte.
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.packet_end)
            |-> (r_out.byte_status == ST_LENGTH || r_out.byte_status == ST_BODY))
        else $error("packet end on a hunt byte");

    // Inside the body the offset stays below the packet size.
    a_index_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_index > OFS_LEN_LOW) |-> (r_byte_index < r_packet_total))
        else $error("byte index ran past packet end");

    // A full buffer keeps its skid entry while the output stalls.
    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_result.ready) |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost while output stalled");
`endif

endmodule
